FILE: sv/rne_pkg.sv
// Package for the Roman numeral encoder: symbol group table and shared types.
`default_nettype none
package rne_pkg;

   localparam int ValueWidth  = 12;
   localparam int SymbolWidth = 8;
   localparam int GroupCount  = 13;
   localparam int GroupWidth  = $clog2(GroupCount);
   localparam logic [ValueWidth-1:0] MaxValue = ValueWidth'(3999);

   localparam logic [SymbolWidth-1:0] SymNone = 8'h00;
   localparam logic [SymbolWidth-1:0] SymI    = 8'h49;
   localparam logic [SymbolWidth-1:0] SymV    = 8'h56;
   localparam logic [SymbolWidth-1:0] SymX    = 8'h58;
   localparam logic [SymbolWidth-1:0] SymL    = 8'h4C;
   localparam logic [SymbolWidth-1:0] SymC    = 8'h43;
   localparam logic [SymbolWidth-1:0] SymD    = 8'h44;
   localparam logic [SymbolWidth-1:0] SymM    = 8'h4D;

   typedef struct packed {
      logic load;
      logic step;
   } rne_cmd_type;

   typedef struct packed {
      logic step_last;
   } rne_status_type;

   function automatic logic [ValueWidth-1:0] group_weight(input logic [GroupWidth-1:0] g);
      logic [ValueWidth-1:0] w;
      case (g)
         4'd0:    w = 12'd1000;
         4'd1:    w = 12'd900;
         4'd2:    w = 12'd500;
         4'd3:    w = 12'd400;
         4'd4:    w = 12'd100;
         4'd5:    w = 12'd90;
         4'd6:    w = 12'd50;
         4'd7:    w = 12'd40;
         4'd8:    w = 12'd10;
         4'd9:    w = 12'd9;
         4'd10:   w = 12'd5;
         4'd11:   w = 12'd4;
         default: w = 12'd1;
      endcase
      return w;
   endfunction

   function automatic logic [SymbolWidth-1:0] group_first(input logic [GroupWidth-1:0] g);
      logic [SymbolWidth-1:0] s;
      case (g)
         4'd0:    s = SymM;
         4'd1:    s = SymC;
         4'd2:    s = SymD;
         4'd3:    s = SymC;
         4'd4:    s = SymC;
         4'd5:    s = SymX;
         4'd6:    s = SymL;
         4'd7:    s = SymX;
         4'd8:    s = SymX;
         4'd9:    s = SymI;
         4'd10:   s = SymV;
         4'd11:   s = SymI;
         default: s = SymI;
      endcase
      return s;
   endfunction

   // Second letter of a subtractive pair, SymNone for a single-letter group.
   function automatic logic [SymbolWidth-1:0] group_second(input logic [GroupWidth-1:0] g);
      logic [SymbolWidth-1:0] s;
      case (g)
         4'd1:    s = SymM;
         4'd3:    s = SymD;
         4'd5:    s = SymC;
         4'd7:    s = SymL;
         4'd9:    s = SymX;
         4'd11:   s = SymV;
         default: s = SymNone;
      endcase
      return s;
   endfunction

   // Largest group whose weight still fits in the remainder.
   function automatic logic [GroupWidth-1:0] pick_group(input logic [ValueWidth-1:0] rest);
      logic [GroupWidth-1:0] sel;
      sel = GroupWidth'(GroupCount - 1);
      for (int g = GroupCount - 1; g >= 0; g--) begin
         if (rest >= group_weight(GroupWidth'(g))) begin
            sel = GroupWidth'(g);
         end
      end
      return sel;
   endfunction

endpackage
`default_nettype wire

FILE: sv/rne_datapath.sv
// Datapath of the Roman numeral encoder: remainder, pending letter and result register.
`default_nettype none
module rne_datapath
   import rne_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [ValueWidth-1:0]  req_value,
   input  wire rne_cmd_type            cmd,
   output rne_status_type              status,
   output logic [SymbolWidth-1:0]      rsp_symbol,
   output logic                        rsp_last,
   output logic                        rsp_invalid
);

   logic [ValueWidth-1:0]  rest_ff, rest_in;
   logic [SymbolWidth-1:0] second_ff, second_in;
   logic                   pend_ff, pend_in;
   logic                   inv_ff, inv_in;
   logic [SymbolWidth-1:0] symbol_ff, symbol_in;
   logic                   last_ff, last_in;
   logic                   invalid_ff, invalid_in;

   logic [GroupWidth-1:0]  grp;
   logic [ValueWidth-1:0]  rest_after;
   logic [SymbolWidth-1:0] grp_second;
   logic                   emit_last;

   assign grp        = pick_group(rest_ff);
   assign rest_after = rest_ff - group_weight(grp);
   assign grp_second = group_second(grp);

   always_comb begin
      if (inv_ff) begin
         emit_last = 1'b1;
      end else if (pend_ff) begin
         emit_last = (rest_ff == '0);
      end else begin
         emit_last = (grp_second == SymNone) && (rest_after == '0);
      end
   end

   assign status.step_last = emit_last;

   always_comb begin
      rest_in    = rest_ff;
      second_in  = second_ff;
      pend_in    = pend_ff;
      inv_in     = inv_ff;
      symbol_in  = symbol_ff;
      last_in    = last_ff;
      invalid_in = invalid_ff;
      if (cmd.load) begin
         rest_in = req_value;
         pend_in = 1'b0;
         inv_in  = (req_value == '0) || (req_value > MaxValue);
      end else if (cmd.step) begin
         last_in    = emit_last;
         invalid_in = inv_ff;
         if (inv_ff) begin
            symbol_in = SymNone;
         end else if (pend_ff) begin
            symbol_in = second_ff;
            pend_in   = 1'b0;
         end else begin
            // The weight is taken off with the first letter of a pair.
            symbol_in = group_first(grp);
            rest_in   = rest_after;
            second_in = grp_second;
            pend_in   = (grp_second != SymNone);
         end
      end
   end

   always_ff @(posedge clock) begin
      rest_ff    <= rest_in;
      second_ff  <= second_in;
      pend_ff    <= pend_in;
      inv_ff     <= inv_in;
      symbol_ff  <= symbol_in;
      last_ff    <= last_in;
      invalid_ff <= invalid_in;
   end

   assign rsp_symbol  = symbol_ff;
   assign rsp_last    = last_ff;
   assign rsp_invalid = invalid_ff;

endmodule
`default_nettype wire

FILE: sv/rne_ctrl.sv
// Controller of the Roman numeral encoder: request intake and result handshake.
`default_nettype none
module rne_ctrl
   import rne_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rne_cmd_type        cmd,
   input  wire rne_status_type status
);

   localparam logic StIdle = 1'b0;
   localparam logic StRun  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign req_ready = (state_ff == StIdle);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.load     = 1'b0;
      cmd.step     = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StRun;
            end
         end
         StRun: begin
            if (slot_free) begin
               cmd.step     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.step_last) begin
                  state_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: sv/roman_numeral_encoder.sv
// Roman numeral encoder: number in, one ASCII numeral letter per result out.
//
// A request carries a 12-bit number on req_value. For 1 to 3999 the block
// returns the numeral in subtractive notation, one letter per result on
// rsp_symbol, most significant first, with rsp_last set on the final letter.
// Zero and values above 3999 give a single result with symbol 0, rsp_invalid
// and rsp_last set.
// The request is loaded into the remainder register; once the result register
// is free, the first letter is stepped into it, and one letter follows per
// cycle while the receiver takes them. The block takes no new request until
// the final letter of a numeral is generated, the longest being that of
// 3888. Letters leave through the single result register one at a time.
// req_ready is high between numerals, also while the final letter of the
// previous one still waits in the result register.
// When the receiver stalls, the waiting letter holds and letter generation
// pauses. Reset returns the controller to idle and drops rsp_valid.
`default_nettype none
module roman_numeral_encoder
   import rne_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [ValueWidth-1:0]  req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [SymbolWidth-1:0]      rsp_symbol,
   output logic                        rsp_last,
   output logic                        rsp_invalid
);

   rne_cmd_type    cmd;
   rne_status_type status;

   rne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   rne_datapath u_datapath (
      .clock       (clock),
      .req_value   (req_value),
      .cmd         (cmd),
      .status      (status),
      .rsp_symbol  (rsp_symbol),
      .rsp_last    (rsp_last),
      .rsp_invalid (rsp_invalid)
   );

endmodule
`default_nettype wire

FILE: test/tb_rne_scoreboard_pkg.sv
// Scoreboard for the Roman numeral encoder testbench: numeral prediction and letter checks.
package tb_rne_scoreboard_pkg;
   import rne_pkg::*;

   typedef struct packed {
      logic [SymbolWidth-1:0] symbol;
      logic                   last;
      logic                   invalid;
   } numeral_letter_type;

   localparam int unsigned NumeralWeight [13] = '{
      1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
   };
   localparam logic [SymbolWidth-1:0] NumeralLead [13] = '{
      SymM, SymC, SymD, SymC, SymC, SymX, SymL, SymX, SymX, SymI, SymV, SymI, SymI
   };
   localparam logic [SymbolWidth-1:0] NumeralTrail [13] = '{
      SymNone, SymM, SymNone, SymD, SymNone, SymC, SymNone, SymL, SymNone, SymX,
      SymNone, SymV, SymNone
   };

   class numeral_scoreboard_type;
      numeral_letter_type pending_letters[$];
      int unsigned        mismatches;

      function void note_request(input logic [ValueWidth-1:0] value);
         numeral_letter_type numeral[$];
         int unsigned        rest;
         rest = value;
         if (rest == 0 || rest > MaxValue) begin
            numeral.push_back('{symbol: SymNone, last: 1'b1, invalid: 1'b1});
         end else begin
            for (int g = 0; g < 13; g++) begin
               while (rest >= NumeralWeight[g]) begin
                  numeral.push_back('{symbol: NumeralLead[g], last: 1'b0, invalid: 1'b0});
                  if (NumeralTrail[g] != SymNone) begin
                     numeral.push_back('{symbol: NumeralTrail[g], last: 1'b0, invalid: 1'b0});
                  end
                  rest -= NumeralWeight[g];
               end
            end
            numeral[numeral.size() - 1].last = 1'b1;
         end
         foreach (numeral[i]) pending_letters.push_back(numeral[i]);
      endfunction

      function void check_letter(input logic [SymbolWidth-1:0] symbol, input logic last,
                                 input logic invalid);
         numeral_letter_type want;
         if (pending_letters.size() == 0) begin
            $display("%0t: unexpected result symbol=%h last=%b invalid=%b",
                     $time, symbol, last, invalid);
            mismatches++;
            return;
         end
         want = pending_letters.pop_front();
         if (want.symbol !== symbol || want.last !== last || want.invalid !== invalid) begin
            $display({"%0t: mismatch, expected symbol=%h last=%b invalid=%b,",
                      " got symbol=%h last=%b invalid=%b"},
                     $time, want.symbol, want.last, want.invalid, symbol, last, invalid);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_letters.size();
      endfunction
   endclass

endpackage

FILE: test/tb_roman_numeral_encoder.sv
// Testbench top for the Roman numeral encoder: drives numbers and checks each numeral letter.
module tb_roman_numeral_encoder;
   import rne_pkg::*;
   import tb_rne_scoreboard_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int          TailCycles = 24;
   localparam int          PhaseItems = 52;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ValueWidth-1:0]  req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SymbolWidth-1:0] rsp_symbol;
   logic                   rsp_last;
   logic                   rsp_invalid;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;

   numeral_scoreboard_type numerals = new;

   always #5 clock = ~clock;

   roman_numeral_encoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_symbol  (rsp_symbol),
      .rsp_last    (rsp_last),
      .rsp_invalid (rsp_invalid)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         numerals.check_letter(rsp_symbol, rsp_last, rsp_invalid);
      end
   end

   // Holds off a random number of cycles, then offers the request until it is taken.
   // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
   task automatic send_value(input logic [ValueWidth-1:0] value);
      int unsigned gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      numerals.note_request(value);
   endtask

   // The last request has been taken, so valid drops before the idle block could take it again.
   task automatic wait_numerals_drained();
      req_valid <= 1'b0;
      while (numerals.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [ValueWidth-1:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         if ($urandom_range(0, 1) == 0) return '0;
         return ValueWidth'($urandom_range(4000, 4095));
      end
      if (pick < 22) return ValueWidth'($urandom_range(1, 60));
      // Digit-wise numbers favor the subtractive fours and nines at the hundreds, tens and units levels.
      if (pick < 40) begin
         return ValueWidth'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                            + $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
      end
      return ValueWidth'($urandom_range(1, 3999));
   endfunction

   initial begin
      int unsigned directed[$];
      directed = '{
         1, 4, 5, 9, 10, 14, 40, 50, 90, 99, 400, 444, 500, 900, 999, 1000,
         1994, 2048, 1365, 2730, 3888, 3999, 0, 4000, 4095
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_value(ValueWidth'(directed[i]));

      for (int phase = 0; phase < 4; phase++) begin
         // The sender pauses here until every letter in flight has come back.
         wait_numerals_drained();
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 63;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 63;
            end
            default: begin
               send_idle_pct = 19;
               stall_pct = 19;
            end
         endcase
         repeat (PhaseItems) send_value(random_value());
      end

      req_valid <= 1'b0;
      wait_numerals_drained();
      repeat (TailCycles) @(posedge clock);
      if (numerals.mismatches == 0 && numerals.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
